/* rtl/sfid_pkg.sv */
// shared constants, codes and types of the smallest free id allocator
package sfid_pkg;

  // pool geometry
  localparam int unsigned PoolSize = 1024;
  localparam int unsigned IdW      = 10;
  localparam int unsigned CntW     = 11;
  localparam int unsigned WordW    = 32;
  localparam int unsigned BitW     = 5;
  localparam int unsigned NumWords = PoolSize / WordW;
  localparam int unsigned WAddrW   = IdW - BitW;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_DEAD  = 2'd3;

  // lowest set bit search result
  typedef struct packed {
    logic            found;
    logic [BitW-1:0] idx;
  } sfid_prio_t;

endpackage

/* rtl/sfid_prio32.sv */
// lowest set bit finder over one 32-bit bitmap word
module sfid_prio32 (
  input  logic [sfid_pkg::WordW-1:0] vec_i,
  output sfid_pkg::sfid_prio_t       res_o
);
  import sfid_pkg::*;

  // scan from the top so the lowest set bit wins
  always_comb begin
    res_o.found = 1'b0;
    res_o.idx   = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        res_o.found = 1'b1;
        res_o.idx   = BitW'(i);
      end
    end
  end

endmodule

/* rtl/smallest_free_id_allocator.sv */
// top level of the smallest free id allocator
//
// Hands out and takes back identifiers from a pool of 1024.
// Input stream: tuser carries the op (0 allocate, 1 free), tdata[9:0] the
// identifier to free (ignored on allocate).
// Output stream: one result transfer per request. tdata[9:0] holds the
// allocated identifier (zero unless an allocate succeeded), tdata[20:10] the
// number of live identifiers after the request, tuser the status
// (0 ok, 1 pool full, 2 out of range, 3 identifier not live).
// An allocate always yields the lowest identifier whose live bit is clear.
// The live bitmap sits in a 32 x 32 memory with a registered read; a
// per-word full flag picks the first word with a clear bit, and the word is
// read, modified and written back.
// Each request passes through the idle state, whose accept cycle issues the
// bitmap read, and the exec state, which searches the word, writes it back
// and loads the result register; a new request is taken only back in idle.
// If the receiver stalls, the result waits in the output register and the
// block holds its exec state until the result register frees up.
// Reset clears the word valid and full flags and the live count at once, so
// every identifier reads as free; no clearing pass is needed.
module smallest_free_id_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] entity_id
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [9:0] allocated_id, [20:10] live_count
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import sfid_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                state_q, state_d;
  logic                op_q;
  logic [IdW-1:0]      id_q;
  logic [WAddrW-1:0]   wsel_q;
  logic [NumWords-1:0] word_vld_q;
  logic [NumWords-1:0] word_full_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [WordW-1:0]    bitmap_mem [NumWords];
  logic [WordW-1:0]    rdata_q;
  logic                rd_vld_q;

  logic                accept;
  logic                done;
  logic [WAddrW-1:0]   raddr;
  logic [WordW-1:0]    word_eff;
  logic [WordW-1:0]    wdata;
  logic                mem_we;
  logic [IdW-1:0]      res_id;
  logic [1:0]          res_st;
  sfid_prio_t          word_pick;
  sfid_prio_t          bit_pick;

  logic                m_vld_q;
  logic [IdW-1:0]      m_id_q;
  logic [1:0]          m_st_q;
  logic [CntW-1:0]     m_cnt_q;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign done            = (state_q == S_EXEC) && (!m_vld_q || m_axis_tready_i);

  // first word that still has a clear bit, and the lowest clear bit of the word
  sfid_prio32 u_word_pick (
    .vec_i (~word_full_q),
    .res_o (word_pick)
  );

  assign word_eff = rd_vld_q ? rdata_q : '0;

  sfid_prio32 u_bit_pick (
    .vec_i (~word_eff),
    .res_o (bit_pick)
  );

  // read address chosen at accept
  always_comb begin
    if (s_axis_tuser_i == OP_FREE) begin
      raddr = s_axis_tdata_i[IdW-1:BitW];
    end else begin
      raddr = word_pick.idx;
    end
  end

  // modify step on the word read back
  always_comb begin
    res_id = '0;
    res_st = ST_OK;
    wdata  = word_eff;
    mem_we = 1'b0;
    cnt_d  = cnt_q;
    if (op_q == OP_ALLOC) begin
      if (cnt_q >= CntW'(PoolSize) || !bit_pick.found) begin
        res_st = ST_FULL;
      end else begin
        res_id = {wsel_q, bit_pick.idx};
        wdata  = word_eff | (WordW'(1) << bit_pick.idx);
        mem_we = 1'b1;
        cnt_d  = cnt_q + CntW'(1);
      end
    end else begin
      if ({1'b0, id_q} >= CntW'(PoolSize)) begin
        res_st = ST_RANGE;
      end else if (!word_eff[id_q[BitW-1:0]]) begin
        res_st = ST_DEAD;
      end else begin
        wdata  = word_eff & ~(WordW'(1) << id_q[BitW-1:0]);
        mem_we = 1'b1;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      word_vld_q  <= '0;
      word_full_q <= '0;
      cnt_q       <= '0;
      m_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        cnt_q   <= cnt_d;
        m_vld_q <= 1'b1;
        if (mem_we) begin
          word_vld_q[wsel_q]  <= 1'b1;
          word_full_q[wsel_q] <= &wdata;
        end
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= s_axis_tuser_i;
      id_q     <= s_axis_tdata_i[IdW-1:0];
      wsel_q   <= raddr;
      rd_vld_q <= word_vld_q[raddr];
    end
    if (done) begin
      m_id_q  <= res_id;
      m_st_q  <= res_st;
      m_cnt_q <= cnt_d;
    end
  end

  // live bitmap memory
  always_ff @(posedge clk_i) begin
    if (done && mem_we) begin
      bitmap_mem[wsel_q] <= wdata;
    end
    if (accept) begin
      rdata_q <= bitmap_mem[raddr];
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {3'b000, m_cnt_q, m_id_q};
  assign m_axis_tuser_o  = m_st_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PoolSize))
    else $error("live count above pool size");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && op_q == OP_ALLOC && res_st == ST_FULL) |-> (cnt_q == CntW'(PoolSize)))
    else $error("pool reported full with free identifiers left");

  a_alloc_free_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && op_q == OP_ALLOC && res_st == ST_OK) |-> !word_eff[bit_pick.idx])
    else $error("allocated identifier was already live");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("second request taken while one is in flight");
`endif

endmodule
